// File: design/unsigned_decimal_text_parser_macros.svh
// ----------------------------------------------------------------------------
// unsigned_decimal_text_parser_macros.svh
// Assertion macros for the unsigned decimal text parser.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_DECIMAL_TEXT_PARSER_MACROS_SVH
`define UNSIGNED_DECIMAL_TEXT_PARSER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define UDTP_ASSERT_IMP(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("udtp assertion failed");
// next-cycle implication
`define UDTP_ASSERT_NXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("udtp assertion failed");
`else
`define UDTP_ASSERT_IMP(label, clk, rstn, a, b)
`define UDTP_ASSERT_NXT(label, clk, rstn, a, b)
`endif
`endif

// File: design/udtp_pkg.sv
// ----------------------------------------------------------------------------
// udtp_pkg
// Types and constants shared by the unsigned decimal text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package udtp_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 64;

    localparam logic [CHAR_W-1:0]  CHAR_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0]  CHAR_PLUS   = 8'h2B;  // '+'
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0]  CHAR_NINE   = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0]  BLANK_MAX   = 8'd32;  // blanks are 1..32
    localparam logic [VALUE_W-1:0] TENTH_OF_MAX = 64'd1844674407370955161;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_SIGN  = 3'd1,
        PH_DIGIT = 3'd2,
        PH_TRAIL = 3'd3,
        PH_BAD   = 3'd4
    } phase_t;

    // byte held in the input register
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] char_code;
    } in_item_t;

    // result written into the output register
    typedef struct packed {
        logic               load;
        logic               ok;
        logic [VALUE_W-1:0] value;
    } result_t;

    // parser state seen from outside the core
    typedef struct packed {
        phase_t phase;
        logic   acc_zero;
    } core_status_t;

endpackage

`default_nettype wire

// File: design/udtp_in_reg.sv
// ----------------------------------------------------------------------------
// udtp_in_reg
// Input register: takes one byte per cycle from the slave channel if ready.
// ----------------------------------------------------------------------------
`default_nettype none

module udtp_in_reg (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [udtp_pkg::CHAR_W-1:0] s_tdata,
    input  wire logic                      consume,
    output udtp_pkg::in_item_t             item
);

    logic                        valid_reg;
    logic [udtp_pkg::CHAR_W-1:0] char_reg;

    // free when empty or when the held byte leaves this cycle
    assign s_tready = !valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            char_reg <= s_tdata;
        end
    end

    assign item.valid     = valid_reg;
    assign item.char_code = char_reg;

endmodule

`default_nettype wire

// File: design/udtp_parse_core.sv
// ----------------------------------------------------------------------------
// udtp_parse_core
// Phase and accumulator update for one byte; builds the result on a NUL.
// ----------------------------------------------------------------------------
`default_nettype none

module udtp_parse_core (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire udtp_pkg::in_item_t      item,
    input  wire logic                    out_free,
    output logic                         consume,
    output udtp_pkg::result_t            result,
    output udtp_pkg::core_status_t       status
);

    udtp_pkg::phase_t               phase_reg, phase_next;
    logic [udtp_pkg::VALUE_W-1:0]   acc_reg, acc_next;

    logic                           is_term, is_blank, is_numeral, is_plus;
    logic [3:0]                     digit;
    logic [udtp_pkg::VALUE_W-1:0]   acc_times10, acc_digit;
    logic                           ovf;

    assign is_term    = (item.char_code == udtp_pkg::CHAR_NUL);
    assign is_blank   = !is_term && (item.char_code <= udtp_pkg::BLANK_MAX);
    assign is_numeral = (item.char_code >= udtp_pkg::CHAR_ZERO) &&
                        (item.char_code <= udtp_pkg::CHAR_NINE);
    assign is_plus    = (item.char_code == udtp_pkg::CHAR_PLUS);

    assign digit       = 4'(item.char_code - udtp_pkg::CHAR_ZERO);
    // x*10 = x*8 + x*2, wraps mod 2^64 (overflow caught separately)
    assign acc_times10 = (acc_reg << 3) + (acc_reg << 1);
    assign acc_digit   = acc_times10 + {{(udtp_pkg::VALUE_W-4){1'b0}}, digit};
    assign ovf         = (acc_reg > udtp_pkg::TENTH_OF_MAX) ||
                         ((acc_reg == udtp_pkg::TENTH_OF_MAX) && (digit > 4'd5));

    // a NUL waits only while the output register is still full
    assign consume = item.valid && (!is_term || out_free);

    always_comb begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        result.load  = 1'b0;
        result.ok    = 1'b0;
        result.value = '0;
        if (consume) begin
            if (is_term) begin
                result.load = 1'b1;
                result.ok   = (phase_reg == udtp_pkg::PH_DIGIT) ||
                              (phase_reg == udtp_pkg::PH_TRAIL);
                result.value = result.ok ? acc_reg : '0;
                phase_next  = udtp_pkg::PH_LEAD;
                acc_next    = '0;
            end else begin
                unique case (phase_reg)
                    udtp_pkg::PH_LEAD: begin
                        if (is_blank) begin
                            phase_next = udtp_pkg::PH_LEAD;
                        end else if (is_plus) begin
                            phase_next = udtp_pkg::PH_SIGN;
                        end else if (is_numeral) begin
                            acc_next   = {{(udtp_pkg::VALUE_W-4){1'b0}}, digit};
                            phase_next = udtp_pkg::PH_DIGIT;
                        end else begin
                            phase_next = udtp_pkg::PH_BAD;
                        end
                    end
                    udtp_pkg::PH_SIGN: begin
                        if (is_numeral) begin
                            acc_next   = {{(udtp_pkg::VALUE_W-4){1'b0}}, digit};
                            phase_next = udtp_pkg::PH_DIGIT;
                        end else begin
                            phase_next = udtp_pkg::PH_BAD;
                        end
                    end
                    udtp_pkg::PH_DIGIT: begin
                        if (is_numeral) begin
                            if (ovf) begin
                                phase_next = udtp_pkg::PH_BAD;
                            end else begin
                                acc_next = acc_digit;
                            end
                        end else if (is_blank) begin
                            phase_next = udtp_pkg::PH_TRAIL;
                        end else begin
                            phase_next = udtp_pkg::PH_BAD;
                        end
                    end
                    udtp_pkg::PH_TRAIL: begin
                        if (!is_blank) begin
                            phase_next = udtp_pkg::PH_BAD;
                        end
                    end
                    default: begin
                        phase_next = udtp_pkg::PH_BAD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= udtp_pkg::PH_LEAD;
            acc_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
        end
    end

    assign status.phase    = phase_reg;
    assign status.acc_zero = (acc_reg == '0);

endmodule

`default_nettype wire

// File: design/udtp_out_reg.sv
// ----------------------------------------------------------------------------
// udtp_out_reg
// Output register: holds one result until the master channel takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module udtp_out_reg (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire udtp_pkg::result_t            result,
    output logic                              out_free,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [udtp_pkg::VALUE_W-1:0]      m_tdata,
    output logic [0:0]                        m_tuser
);

    logic                         valid_reg;
    logic                         ok_reg;
    logic [udtp_pkg::VALUE_W-1:0] value_reg;

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (result.load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.load) begin
            ok_reg    <= result.ok;
            value_reg <= result.value;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = ok_reg;

endmodule

`default_nettype wire

// File: design/unsigned_decimal_text_parser.sv
// ----------------------------------------------------------------------------
// unsigned_decimal_text_parser
// Parses NUL-terminated ASCII text into a 64-bit unsigned value.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                  | tuser        | item
//  --------+-----+------------------------+--------------+---------------------
//  s_      | in  | [7:0]  char_code       | -            | one text byte
//  m_      | out | [63:0] parsed_value    | [0] parse_ok | one per NUL byte
//
//  Throughput: one byte per cycle while s_tready is high. A byte is
//  registered, then the phase and accumulator update (x*10 + digit and
//  the overflow compare) runs on it; a NUL's result is registered for m_.
//  Reset (aresetn low, synchronous) clears phase to leading-blank, zeroes the
//  accumulator and empties both registers.
//  Stalls: s_tready drops only while a NUL waits behind an untaken result.
//
`default_nettype none

module unsigned_decimal_text_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // slave channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    // master channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [63:0] parsed_value
    output logic [0:0]       m_tuser    // [0] parse_ok
);

`include "unsigned_decimal_text_parser_macros.svh"

    udtp_pkg::in_item_t     in_item;
    udtp_pkg::result_t      result;
    udtp_pkg::core_status_t status;
    logic                   consume;
    logic                   out_free;

    // input register
    udtp_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .consume  (consume),
        .item     (in_item)
    );

    // phase / accumulator update
    udtp_parse_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (in_item),
        .out_free (out_free),
        .consume  (consume),
        .result   (result),
        .status   (status)
    );

    // result register
    udtp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // a rejected string always reports zero
    `UDTP_ASSERT_IMP(a_bad_is_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0)
    // input stalls only behind a NUL with the output still full
    `UDTP_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_tready,
        in_item.valid && (in_item.char_code == udtp_pkg::CHAR_NUL) && m_tvalid && !m_tready)
    // parser is back at its start state after every result
    `UDTP_ASSERT_NXT(a_restart, aclk, aresetn, result.load,
        (status.phase == udtp_pkg::PH_LEAD) && status.acc_zero && m_tvalid)

endmodule

`default_nettype wire

// File: verif/unsigned_decimal_text_parser_test.sv
// ----------------------------------------------------------------------------
// unsigned_decimal_text_parser_test
// Self-checking bench: NUL-terminated text in, one (parse_ok, value) per NUL.
// ----------------------------------------------------------------------------
// A queue of text bytes, each with its own idle gap, feeds a clocked driver.
// A clocked monitor runs every accepted byte through a local parser model
// and checks each result item against the oldest predicted one. The text
// starts with a few hand-picked strings, then moves on to random strings:
// mostly well-formed numbers, values at the 64-bit edge, corrupted strings
// and raw byte noise. Both sides stall at random. The receiver also holds
// off for long stretches so the block backs up, and the sender sometimes
// waits for every pending result before it starts a string.
// ----------------------------------------------------------------------------

module unsigned_decimal_text_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam int TEXT_BYTES = 1750;           // random text volume
    // Slowest good run: ~1800 bytes, each after its own idle gap, ~250 results
    // that each may wait on the receiver, two long hold-offs and the drain
    // pauses. RUN_LIMIT leaves several times that.
    localparam int RUN_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [7:0]  code;
        int unsigned gap;        // idle cycles before this byte is offered
        bit          wait_drain; // hold this byte until no result is pending
    } text_byte_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] value;
    } parse_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;

    unsigned_decimal_text_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model state
    // ------------------------------------------------------------------
    udtp_pkg::phase_t parse_phase = udtp_pkg::PH_LEAD;
    logic [63:0]      parse_acc = '0;

    text_byte_t    text_q[$];     // bytes still to be offered
    logic [7:0]    text_buf[$];   // string under construction
    parse_result_t result_q[$];   // predicted results not yet seen

    int  tx_mode = 0;
    int  cycle_count = 0;
    int  failures = 0;
    int  bytes_accepted = 0;
    int  results_seen = 0;
    int  ok_count = 0;
    int  bad_count = 0;
    int  overflow_count = 0;
    int  stall_cycles = 0;
    bit  in_taken = 1'b0;         // s_ handshake at the last rising edge

    // Multiply-accumulate one digit; 0 when the value would pass 2^64-1.
    function automatic logic add_digit(input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - udtp_pkg::CHAR_ZERO);
        if (parse_acc > udtp_pkg::TENTH_OF_MAX ||
            (parse_acc == udtp_pkg::TENTH_OF_MAX && d > 64'd5))
            return 1'b0;
        parse_acc = parse_acc * 64'd10 + d;
        return 1'b1;
    endfunction

    // Advance the model by one byte; returns 1 with res filled on a NUL.
    function automatic logic parse_byte(input logic [7:0] c, output parse_result_t res);
        logic blank;
        logic digit;
        blank = (c != udtp_pkg::CHAR_NUL) && (c <= udtp_pkg::BLANK_MAX);
        digit = (c >= udtp_pkg::CHAR_ZERO) && (c <= udtp_pkg::CHAR_NINE);
        res = '0;
        if (c == udtp_pkg::CHAR_NUL) begin
            res.ok = (parse_phase == udtp_pkg::PH_DIGIT) ||
                     (parse_phase == udtp_pkg::PH_TRAIL);
            res.value = res.ok ? parse_acc : '0;
            parse_phase = udtp_pkg::PH_LEAD;
            parse_acc = '0;
            return 1'b1;
        end
        case (parse_phase)
            udtp_pkg::PH_LEAD: begin
                if (c == udtp_pkg::CHAR_PLUS) begin
                    parse_phase = udtp_pkg::PH_SIGN;
                end else if (digit) begin
                    parse_acc = '0;
                    void'(add_digit(c));
                    parse_phase = udtp_pkg::PH_DIGIT;
                end else if (!blank) begin
                    parse_phase = udtp_pkg::PH_BAD;
                end
            end
            udtp_pkg::PH_SIGN: begin
                if (digit) begin
                    parse_acc = '0;
                    void'(add_digit(c));
                    parse_phase = udtp_pkg::PH_DIGIT;
                end else begin
                    parse_phase = udtp_pkg::PH_BAD;
                end
            end
            udtp_pkg::PH_DIGIT: begin
                if (digit) begin
                    if (!add_digit(c)) begin
                        parse_phase = udtp_pkg::PH_BAD;
                        overflow_count++;
                    end
                end else if (blank) begin
                    parse_phase = udtp_pkg::PH_TRAIL;
                end else begin
                    parse_phase = udtp_pkg::PH_BAD;
                end
            end
            udtp_pkg::PH_TRAIL: begin
                if (!blank)
                    parse_phase = udtp_pkg::PH_BAD;
            end
            default: parse_phase = udtp_pkg::PH_BAD;
        endcase
        return 1'b0;
    endfunction

    // Idle length: mode 0 never idles, 1 mostly short, 2 busier with long gaps.
    function automatic int unsigned idle_len(input int mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        return (r < 40) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(10, 40);
    endfunction

    task automatic log_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // String building
    // ------------------------------------------------------------------
    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(8'(s[i]));
    endtask

    task automatic append_digits(input int n);
        for (int i = 0; i < n; i++)
            text_buf.push_back(udtp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic append_blanks(input int n);
        for (int i = 0; i < n; i++)
            text_buf.push_back(8'($urandom_range(1, 32)));
    endtask

    // Move the built string plus its NUL into the send queue.
    task automatic submit_string(input bit drain_first);
        text_byte_t tb;
        text_buf.push_back(udtp_pkg::CHAR_NUL);
        foreach (text_buf[i]) begin
            tb.code = text_buf[i];
            tb.gap = idle_len(tx_mode);
            tb.wait_drain = drain_first && (i == 0);
            text_q.push_back(tb);
        end
        text_buf.delete();
    endtask

    // A plain number: optional blanks, optional '+', digits, optional blanks.
    task automatic append_number();
        logic [63:0] v;
        append_blanks(($urandom_range(0, 1) == 1) ? $urandom_range(1, 3) : 0);
        if ($urandom_range(0, 9) < 3)
            text_buf.push_back(udtp_pkg::CHAR_PLUS);
        if ($urandom_range(0, 9) == 0)
            append_text("00");
        if ($urandom_range(0, 1) == 1) begin
            append_digits($urandom_range(1, 6));
        end else begin
            v = {$urandom, $urandom} >> $urandom_range(0, 63);
            append_text($sformatf("%0d", v));
        end
        append_blanks(($urandom_range(0, 1) == 1) ? $urandom_range(1, 3) : 0);
    endtask

    // Values around 2^64-1, including the last-digit-above-5 limit.
    task automatic append_edge_number();
        case ($urandom_range(0, 3))
            0: append_text($sformatf("%0d", 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 12))));
            1: begin
                append_text("1844674407370955161");
                text_buf.push_back(udtp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            2: begin
                append_text("1844674407370955161");
                append_digits($urandom_range(2, 3));
            end
            default: begin
                append_text("000");
                append_text($sformatf("%0d", 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3))));
            end
        endcase
        if ($urandom_range(0, 2) == 0)
            append_blanks(1);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued bytes, holds an offer until it is taken.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        text_byte_t next_byte;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (text_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (text_q[0].gap != 0) begin
                text_q[0].gap = text_q[0].gap - 1;
                s_tvalid <= 1'b0;
            end else if (text_q[0].wait_drain && result_q.size() != 0) begin
                s_tvalid <= 1'b0;
            end else begin
                next_byte = text_q.pop_front();
                s_tdata <= next_byte.code;
                s_tvalid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls in changing modes, plus two long hold-offs
    // that let NULs pile up until s_tready drops.
    // ------------------------------------------------------------------
    int unsigned rx_stall = 0;
    int unsigned holdoff_left = 0;
    int          holdoffs_done = 0;
    int          holdoff_at = 15;
    int          rx_mode = 0;
    int          rx_span = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_span == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_span = $urandom_range(50, 250);
            end else begin
                rx_span--;
            end
            if (holdoff_left != 0) begin
                holdoff_left--;
                m_tready <= 1'b0;
            end else if (holdoffs_done < 2 && results_seen >= holdoff_at) begin
                holdoffs_done++;
                holdoff_at = results_seen + 70;
                holdoff_left = $urandom_range(100, 160);
                m_tready <= 1'b0;
            end else if (rx_stall != 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_stall = idle_len(rx_mode);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted bytes, check accepted results.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        parse_result_t predicted;
        parse_result_t expected;
        parse_result_t observed;
        cycle_count++;
        if (!aresetn) begin
            in_taken = 1'b0;
        end else begin
            in_taken = s_tvalid && s_tready;
            if (in_taken) begin
                bytes_accepted++;
                if (parse_byte(s_tdata, predicted))
                    result_q.push_back(predicted);
            end
            if (s_tvalid && !s_tready)
                stall_cycles++;
            if (m_tvalid && m_tready) begin
                observed.ok = m_tuser[0];
                observed.value = m_tdata;
                results_seen++;
                if (observed.ok)
                    ok_count++;
                else
                    bad_count++;
                if (result_q.size() == 0) begin
                    log_failure($sformatf("unexpected result ok=%0b value=%0d",
                                          observed.ok, observed.value));
                end else begin
                    expected = result_q.pop_front();
                    if (observed.ok !== expected.ok || observed.value !== expected.value)
                        log_failure($sformatf(
                            "result %0d: expected ok=%0b value=%0d, got ok=%0b value=%0d",
                            results_seen, expected.ok, expected.value,
                            observed.ok, observed.value));
                end
            end
        end
    end

    // Run-length guard
    initial begin
        while (cycle_count < RUN_LIMIT)
            @(posedge aclk);
        $display("timeout after %0d cycles", cycle_count);
        $display("unsigned_decimal_text_parser: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int kind;
        int pos;
        int strings_done;
        int drain_wait;

        // Hand-picked strings first, no idling.
        tx_mode = 0;
        submit_string(1'b0);                              // empty string
        text_buf.push_back(CHAR_SPACE);                   // blanks only, both ends
        text_buf.push_back(8'h01);                        // of the blank range
        submit_string(1'b0);
        text_buf.push_back(udtp_pkg::CHAR_PLUS);          // sign, no digits
        submit_string(1'b0);
        text_buf.push_back(udtp_pkg::CHAR_PLUS);          // sign then blank
        text_buf.push_back(CHAR_SPACE);
        submit_string(1'b0);
        text_buf.push_back(CHAR_MINUS);                   // minus sign
        append_text("1");
        submit_string(1'b0);
        text_buf.push_back(udtp_pkg::CHAR_PLUS);          // good: sign, digit, blank
        append_text("9");
        text_buf.push_back(CHAR_SPACE);
        submit_string(1'b0);
        append_text("0");                                 // stray high byte
        text_buf.push_back(8'hFF);
        submit_string(1'b0);
        text_buf.push_back(CHAR_TAB);                     // zero after a blank
        append_text("0");
        submit_string(1'b0);

        // Random strings.
        strings_done = 0;
        while (text_q.size() < TEXT_BYTES + 26) begin
            if (strings_done % 25 == 0)
                tx_mode = $urandom_range(0, 2);
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                append_number();
            end else if (kind < 65) begin
                append_edge_number();
            end else if (kind < 85) begin
                append_number();
                case ($urandom_range(0, 2))
                    0: begin
                        pos = $urandom_range(0, text_buf.size() - 1);
                        text_buf[pos] = 8'($urandom_range(1, 255));
                    end
                    1: text_buf.push_front(CHAR_MINUS);
                    default: begin
                        text_buf.push_back(CHAR_SPACE);
                        text_buf.push_back(($urandom_range(0, 1) == 1)
                                           ? udtp_pkg::CHAR_PLUS
                                           : udtp_pkg::CHAR_ZERO
                                             + 8'($urandom_range(0, 9)));
                    end
                endcase
            end else begin
                for (int i = $urandom_range(1, 8); i > 0; i--)
                    text_buf.push_back(8'($urandom_range(1, 255)));
            end
            submit_string(strings_done == 0 || $urandom_range(0, 49) == 0);
            strings_done++;
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // All text taken, then give the results time to drain.
        while (text_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        drain_wait = 0;
        while (result_q.size() != 0 && drain_wait < 3000) begin
            @(posedge aclk);
            drain_wait++;
        end
        repeat (8) @(posedge aclk);
        while (result_q.size() != 0) begin
            log_failure($sformatf("missing result ok=%0b value=%0d",
                                  result_q[0].ok, result_q[0].value));
            void'(result_q.pop_front());
        end

        $display("%0d bytes parsed into %0d strings: %0d valid, %0d rejected (%0d overflow)",
                 bytes_accepted, results_seen, ok_count, bad_count, overflow_count);
        $display("input backpressure on %0d cycles, %0d cycles total, %0d failures",
                 stall_cycles, cycle_count, failures);
        if (failures == 0)
            $display("unsigned_decimal_text_parser: match");
        else
            $display("unsigned_decimal_text_parser: mismatch");
        $finish;
    end

endmodule
